// File: hw/rtl/pcgd_pkg.sv
// pcgd_pkg: shared constants, command codes and the xsh-rr output function
// for the pcg32 random draw unit; no dependencies
package pcgd_pkg;

	localparam logic [63:0] LCG_MULT = 64'd6364136223846793005;
	localparam logic [31:0] LCG_MULT_LO = LCG_MULT[31:0];
	localparam logic [31:0] LCG_MULT_HI = LCG_MULT[63:32];
	localparam logic [63:0] SEED_RESET_STATE = 64'd1;

	localparam int XSH_SHIFT_A = 18;
	localparam int XSH_SHIFT_B = 27;
	localparam int ROT_SHIFT = 59;

	localparam logic [31:0] FRAC23_MASK = 32'h007f_ffff;
	localparam logic [63:0] FRAC52_MASK = 64'h000f_ffff_ffff_ffff;
	localparam logic [31:0] ALPHA_BITS = 32'hff00_0000;

	localparam logic [3:0] CMD_BIT = 4'd0;
	localparam logic [3:0] CMD_RAW32 = 4'd1;
	localparam logic [3:0] CMD_RAW64 = 4'd2;
	localparam logic [3:0] CMD_FRAC23 = 4'd3;
	localparam logic [3:0] CMD_FRAC52 = 4'd4;
	localparam logic [3:0] CMD_RANGE32 = 4'd5;
	localparam logic [3:0] CMD_RANGE64 = 4'd6;
	localparam logic [3:0] CMD_COLOUR = 4'd7;
	localparam logic [3:0] CMD_RESEED = 4'd8;

	// xsh-rr output word of one generator state, true 32-bit rotate right
	function automatic logic [31:0] xsh_rr(input logic [63:0] st);
		logic [63:0] mix;
		logic [31:0] x;
		logic [4:0] rot;
		logic [63:0] dbl;
		logic [63:0] shifted;
		mix = (st >> XSH_SHIFT_A) ^ st;
		x = mix[XSH_SHIFT_B +: 32];
		rot = st[ROT_SHIFT +: 5];
		dbl = {x, x};
		shifted = dbl >> rot;
		return shifted[31:0];
	endfunction

endpackage

// File: hw/rtl/pcgd_lcg.sv
// pcgd_lcg: one lcg advance, state * mult + 1 mod 2^64, in phases
// on a single shared 32x32 multiplier; depends on pcgd_pkg
module pcgd_lcg import pcgd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] state_in,
	output logic        done,
	output logic [63:0] state_out
);

	logic        busy_q;
	logic [1:0]  phase_q;
	logic        done_q;
	logic [31:0] lo_q;
	logic [31:0] hi_q;
	logic [63:0] prod_q;
	logic [63:0] acc_q;
	logic [31:0] mult_a;
	logic [31:0] mult_b;
	logic [63:0] product;

	// lo*mlo, then lo*mhi, then hi*mlo
	assign mult_a = (phase_q == 2'd2) ? hi_q : lo_q;
	assign mult_b = (phase_q == 2'd1) ? LCG_MULT_HI : LCG_MULT_LO;
	assign product = mult_a * mult_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			phase_q <= 2'd0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			phase_q <= 2'd0;
			done_q <= 1'b0;
		end else if (busy_q) begin
			phase_q <= phase_q + 2'd1;
			done_q <= (phase_q == 2'd3);
			busy_q <= (phase_q != 2'd3);
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			lo_q <= state_in[31:0];
			hi_q <= state_in[63:32];
		end else if (busy_q) begin
			prod_q <= product;
			unique case (phase_q)
				2'd0: begin
				end
				2'd1: begin
					acc_q <= prod_q + 64'd1;
				end
				default: begin
					acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
				end
			endcase
		end
	end

	assign done = done_q;
	assign state_out = acc_q;

endmodule

// File: hw/rtl/pcgd_div.sv
// pcgd_div: 64-bit restoring divider, one quotient bit per cycle,
// remainder only; no dependencies beyond plain logic
module pcgd_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        done,
	output logic [63:0] remainder
);

	logic        busy_q;
	logic [5:0]  count_q;
	logic        done_q;
	logic [63:0] rem_q;
	logic [63:0] dvd_q;
	logic [63:0] dvs_q;
	logic [64:0] trial;
	logic [64:0] diff;

	assign trial = {rem_q, dvd_q[63]};
	assign diff = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			count_q <= 6'd0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			count_q <= 6'd0;
			done_q <= 1'b0;
		end else if (busy_q) begin
			count_q <= count_q + 6'd1;
			done_q <= (count_q == 6'd63);
			busy_q <= (count_q != 6'd63);
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 64'd0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[62:0], 1'b0};
			if (!diff[64]) begin
				rem_q <= diff[63:0];
			end else begin
				rem_q <= trial[63:0];
			end
		end
	end

	assign done = done_q;
	assign remainder = rem_q;

endmodule

// File: hw/rtl/pcg32_random_draw_unit_top.sv
// pcg32_random_draw_unit_top: command sequencer, generator state and output register
// depends on pcgd_pkg, pcgd_lcg and pcgd_div
//
// usage:
//   request channel in_valid/in_ready carries command, bound_low, bound_high
//   and seed_value; response channel out_valid/out_ready carries value and
//   range_error, one response per request, in order.
//   one request is in work at a time; in_ready is high only while idle.
//   each draw runs one lcg advance on a shared 32x32 multiplier.
//   bit, raw32, frac23, colour, reseed: one draw each.
//   raw64, frac52: two draws. range commands add a 64-step restoring
//   divider run after their draws: one draw for range32, two for range64.
//   zero range width and unused codes: no draw, state unchanged.
//   a finished response sits in the output register while the next request
//   is taken; if the receiver stalls, the sequencer holds its next response
//   until the output register frees up.
//   after reset the generator state is 1 (one lcg step of seed zero) and
//   no response is pending.
module pcg32_random_draw_unit_top import pcgd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  command,
	input  logic [63:0] bound_low,
	input  logic [63:0] bound_high,
	input  logic [63:0] seed_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] value,
	output logic        range_error
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LAUNCH = 3'd1;
	localparam logic [2:0] ST_STEP = 3'd2;
	localparam logic [2:0] ST_DIV = 3'd3;
	localparam logic [2:0] ST_PUT = 3'd4;

	logic [2:0]  st_q;
	logic        two_q;
	logic        idx_q;
	logic        out_valid_q;
	logic [63:0] gen_q;
	logic [3:0]  cmd_q;
	logic [63:0] low_q;
	logic [63:0] width_q;
	logic [31:0] word_lo_q;
	logic [31:0] word_hi_q;
	logic [63:0] res_value_q;
	logic        res_err_q;
	logic [63:0] value_q;
	logic        range_error_q;

	logic        accept;
	logic        put;
	logic        step_start;
	logic        step_done;
	logic [63:0] step_state;
	logic        div_start;
	logic        div_done;
	logic [63:0] div_rem;
	logic [63:0] w64;
	logic [31:0] w32;
	logic        is_range;
	logic        last_draw;
	logic [63:0] draw_value;
	logic [63:0] range_value;
	logic [31:0] range_sum32;
	logic [63:0] div_dividend;

	assign accept = in_valid && in_ready;
	assign in_ready = (st_q == ST_IDLE);
	assign put = (st_q == ST_PUT) && (!out_valid_q || out_ready);
	assign w64 = bound_high - bound_low;
	assign w32 = bound_high[31:0] - bound_low[31:0];
	assign is_range = (cmd_q == CMD_RANGE32) || (cmd_q == CMD_RANGE64);
	assign last_draw = !two_q || idx_q;
	assign step_start = (st_q == ST_LAUNCH);
	assign div_start = (st_q == ST_STEP) && step_done && last_draw && is_range;
	assign div_dividend = (cmd_q == CMD_RANGE64) ? {word_hi_q, word_lo_q}
		: {32'd0, word_lo_q};
	assign range_sum32 = low_q[31:0] + div_rem[31:0];
	assign range_value = (cmd_q == CMD_RANGE64) ? (low_q + div_rem)
		: {32'd0, range_sum32};

	always_comb begin
		draw_value = 64'd0;
		unique case (cmd_q)
			CMD_BIT: draw_value = {63'd0, word_lo_q[0]};
			CMD_RAW32: draw_value = {32'd0, word_lo_q};
			CMD_RAW64: draw_value = {word_hi_q, word_lo_q};
			CMD_FRAC23: draw_value = {32'd0, word_lo_q & FRAC23_MASK};
			CMD_FRAC52: draw_value = {word_hi_q, word_lo_q} & FRAC52_MASK;
			CMD_COLOUR: draw_value = {32'd0, word_lo_q | ALPHA_BITS};
			default: draw_value = 64'd0;
		endcase
	end

	pcgd_lcg u_lcg (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (step_start),
		.state_in  (gen_q),
		.done      (step_done),
		.state_out (step_state)
	);

	pcgd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (width_q),
		.done      (div_done),
		.remainder (div_rem)
	);

	// sequencer and generator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			two_q <= 1'b0;
			idx_q <= 1'b0;
			gen_q <= SEED_RESET_STATE;
			out_valid_q <= 1'b0;
		end else begin
			if (put) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q <= 1'b0;
						two_q <= (command == CMD_RAW64) || (command == CMD_FRAC52)
							|| (command == CMD_RANGE64);
						priority if (command == CMD_RESEED) begin
							gen_q <= seed_value;
							st_q <= ST_LAUNCH;
						end else if (command == CMD_RANGE32 && w32 == 32'd0) begin
							st_q <= ST_PUT;
						end else if (command == CMD_RANGE64 && w64 == 64'd0) begin
							st_q <= ST_PUT;
						end else if (command > CMD_RESEED) begin
							st_q <= ST_PUT;
						end else begin
							st_q <= ST_LAUNCH;
						end
					end
				end
				ST_LAUNCH: begin
					st_q <= ST_STEP;
				end
				ST_STEP: begin
					if (step_done) begin
						gen_q <= step_state;
						priority if (!last_draw) begin
							idx_q <= 1'b1;
							st_q <= ST_LAUNCH;
						end else if (is_range) begin
							st_q <= ST_DIV;
						end else begin
							st_q <= ST_PUT;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						st_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					if (put) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request payload, draw words and results
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= command;
			if (command == CMD_RANGE32) begin
				low_q <= {32'd0, bound_low[31:0]};
				width_q <= {32'd0, w32};
				res_value_q <= {32'd0, bound_low[31:0]};
				res_err_q <= (w32 == 32'd0);
			end else begin
				low_q <= bound_low;
				width_q <= w64;
				res_value_q <= (command == CMD_RANGE64) ? bound_low : 64'd0;
				res_err_q <= (command == CMD_RANGE64) && (w64 == 64'd0);
			end
		end
		if (st_q == ST_LAUNCH) begin
			if (idx_q) begin
				word_hi_q <= xsh_rr(gen_q);
			end else begin
				word_lo_q <= xsh_rr(gen_q);
			end
		end
		if (st_q == ST_STEP && step_done && last_draw && !is_range) begin
			res_value_q <= draw_value;
		end
		if (st_q == ST_DIV && div_done) begin
			res_value_q <= range_value;
		end
		if (put) begin
			value_q <= res_value_q;
			range_error_q <= res_err_q;
		end
	end

	assign out_valid = out_valid_q;
	assign value = value_q;
	assign range_error = range_error_q;

`ifndef NO_ASSERTIONS
	// the two shared units never finish together
	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(step_done && div_done))
		else $error("lcg unit and divider finished in the same cycle");

	// a taken request blocks the next one
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("request accepted while previous one still in work");

	// divider only starts on a nonzero width
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (width_q != 64'd0))
		else $error("divider started with zero width");

	// a range error is flagged only for a range request and carries no draw
	a_err_is_range: assert property (@(posedge clk) disable iff (!arst_n)
		put && res_err_q |-> ((cmd_q == CMD_RANGE32) || (cmd_q == CMD_RANGE64)))
		else $error("range error flagged for a non-range request");
`endif

endmodule

// File: dv/tb_pcg32_random_draw_unit_top.sv
`timescale 1ns / 1ps
// tb_pcg32_random_draw_unit_top: self-checking testbench for the pcg32 random draw unit,
// directed and random requests checked against a generator-state tracking predictor class
// depends on pcgd_pkg and pcg32_random_draw_unit_top
module tb_pcg32_random_draw_unit_top;
	import pcgd_pkg::*;

	localparam int NUM_RANDOM = 1925;
	localparam int STALL_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 100;
	localparam logic [3:0] CMD_CODE_MAX = 4'hf;

	typedef struct packed {
		logic [63:0] value;
		logic        range_error;
	} draw_result_t;

	class pcg_draw_predictor;
		logic [63:0] gen_state;
		draw_result_t expected_draws[$];
		int mismatches;

		function new();
			gen_state = SEED_RESET_STATE;
			mismatches = 0;
		endfunction

		// one lcg advance, xsh-rr word of the old state
		function logic [31:0] next_word();
			logic [63:0] old;
			logic [63:0] mixed;
			logic [31:0] word;
			logic [4:0] rot;
			old = gen_state;
			gen_state = old * LCG_MULT + 64'd1;
			mixed = ((old >> XSH_SHIFT_A) ^ old) >> XSH_SHIFT_B;
			word = mixed[31:0];
			rot = old[63:59];
			return (word >> rot) | (word << (5'd0 - rot));
		endfunction

		function logic [63:0] next_pair();
			logic [31:0] first;
			logic [31:0] second;
			first = next_word();
			second = next_word();
			return {second, first};
		endfunction

		function void note_request(input logic [3:0] op, input logic [63:0] lo,
			input logic [63:0] hi, input logic [63:0] seed);
			draw_result_t res;
			logic [31:0] word;
			logic [31:0] lo32;
			logic [31:0] width32;
			logic [31:0] sum32;
			logic [63:0] width64;
			res = '0;
			case (op)
			CMD_BIT: begin
				word = next_word();
				res.value = {63'd0, word[0]};
			end
			CMD_RAW32: res.value = {32'd0, next_word()};
			CMD_RAW64: res.value = next_pair();
			CMD_FRAC23: res.value = {32'd0, next_word() & FRAC23_MASK};
			CMD_FRAC52: res.value = next_pair() & FRAC52_MASK;
			CMD_RANGE32: begin
				lo32 = lo[31:0];
				width32 = hi[31:0] - lo32;
				if (width32 == 32'd0) begin
					res.range_error = 1'b1;
					res.value = {32'd0, lo32};
				end else begin
					sum32 = lo32 + next_word() % width32;
					res.value = {32'd0, sum32};
				end
			end
			CMD_RANGE64: begin
				width64 = hi - lo;
				if (width64 == 64'd0) begin
					res.range_error = 1'b1;
					res.value = lo;
				end else begin
					res.value = lo + next_pair() % width64;
				end
			end
			CMD_COLOUR: res.value = {32'd0, next_word() | ALPHA_BITS};
			CMD_RESEED: begin
				gen_state = seed;
				word = next_word();
			end
			default: ;
			endcase
			expected_draws.push_back(res);
		endfunction

		function void check_response(input logic [63:0] got_value, input logic got_error);
			draw_result_t exp_res;
			if (expected_draws.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected response, value %h range_error %b",
					$time, got_value, got_error);
				return;
			end
			exp_res = expected_draws.pop_front();
			if (got_value !== exp_res.value) begin
				mismatches++;
				$display("%0t: value mismatch, expected %h actual %h",
					$time, exp_res.value, got_value);
			end
			if (got_error !== exp_res.range_error) begin
				mismatches++;
				$display("%0t: range_error mismatch, expected %b actual %b",
					$time, exp_res.range_error, got_error);
			end
		endfunction

		function int pending();
			return expected_draws.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [3:0]  command;
	logic [63:0] bound_low;
	logic [63:0] bound_high;
	logic [63:0] seed_value;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] value;
	logic        range_error;

	bit idle_on = 1'b1;
	int quiet_cycles;
	pcg_draw_predictor predictor;

	pcg32_random_draw_unit_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.bound_low   (bound_low),
		.bound_high  (bound_high),
		.seed_value  (seed_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.value       (value),
		.range_error (range_error)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic send_request(input logic [3:0] op, input logic [63:0] lo,
		input logic [63:0] hi, input logic [63:0] seed);
		@(negedge clk);
		while (idle_on && $urandom_range(0, 99) < 33) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		command = op;
		bound_low = lo;
		bound_high = hi;
		seed_value = seed;
		do @(posedge clk); while (!in_ready);
		predictor.note_request(op, lo, hi, seed);
	endtask

	// drop the request line, then wait for every expected response
	task automatic drain_draws();
		@(negedge clk);
		in_valid = 1'b0;
		while (predictor.pending() != 0) @(posedge clk);
	endtask

	task automatic random_request();
		logic [3:0] op;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] seed;
		if ($urandom_range(0, 99) < 6)
			op = 4'($urandom_range(CMD_RESEED + 4'd1, CMD_CODE_MAX));
		else
			op = 4'($urandom_range(CMD_BIT, CMD_RESEED));
		lo = rand64();
		case ($urandom_range(0, 9))
		4, 5: hi = lo + $urandom_range(1, 16);
		6: hi = lo;
		7: hi = {$urandom, lo[31:0]};
		8: begin
			lo = $urandom_range(0, 1) ? '1 : '0;
			hi = $urandom_range(0, 1) ? '1 : '0;
		end
		9: hi = lo + (64'd1 << $urandom_range(0, 63));
		default: hi = rand64();
		endcase
		case ($urandom_range(0, 9))
		0: seed = '0;
		1: seed = '1;
		default: seed = rand64();
		endcase
		send_request(op, lo, hi, seed);
	endtask

	// response side: random stalls, sampled at the rising edge
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready = !(idle_on && $urandom_range(0, 99) < 33);
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				predictor.check_response(value, range_error);
		end
	end

	// watchdog on cycles without any handshake
	initial begin
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		predictor = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_BIT;
		bound_low = '0;
		bound_high = '0;
		seed_value = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// first draws come from the reset state
		send_request(CMD_RAW32, '0, '0, '0);
		send_request(CMD_BIT, '0, '0, '0);
		send_request(CMD_RAW64, '0, '0, '0);
		send_request(CMD_FRAC23, '0, '0, '0);
		send_request(CMD_FRAC52, '0, '0, '0);
		send_request(CMD_COLOUR, '0, '0, '0);
		// range32 zero width, also with differing upper halves, then wrapping and full widths
		send_request(CMD_RANGE32, '0, '0, '0);
		send_request(CMD_RANGE32, 64'h0000_0001_0000_0005, 64'h0000_0002_0000_0005, '0);
		send_request(CMD_RANGE32, 64'h0000_0000_ffff_ffff, '0, '0);
		send_request(CMD_RANGE32, 64'd10, 64'd3, '0);
		send_request(CMD_RANGE32, '0, 64'h0000_0000_ffff_ffff, '0);
		// range64 zero width, full width, width one and wrap
		send_request(CMD_RANGE64, '1, '1, '0);
		send_request(CMD_RANGE64, '0, '1, '0);
		send_request(CMD_RANGE64, '1, '0, '0);
		send_request(CMD_RANGE64, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0007, '0);
		send_request(CMD_RANGE64, 64'd3, 64'h0000_0001_0000_0003, '0);
		send_request(CMD_RESEED, '0, '0, '0);
		send_request(CMD_RAW32, '0, '0, '0);
		send_request(CMD_RESEED, '0, '0, '1);
		send_request(CMD_RAW64, '0, '0, '0);
		send_request(CMD_RESEED + 4'd1, '1, '1, '1);
		send_request(CMD_CODE_MAX, '1, '0, '1);
		send_request(CMD_BIT, '0, '0, '0);
		drain_draws();

		for (int i = 0; i < NUM_RANDOM; i++) begin
			idle_on = !(i >= 600 && i < 900);
			if (i == 1300)
				drain_draws();
			random_request();
		end
		@(negedge clk);
		in_valid = 1'b0;
		idle_on = 1'b1;

		drain_draws();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (predictor.mismatches == 0 && predictor.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
